// ===== rtl/core/sgps_pkg.sv =====
// Shared types and constants of the path smoother.
// Used by sgps_window, sgps_fir and savitzky_golay_path_smoother; no dependencies.
package sgps_pkg;

	localparam int HALF_WINDOW_DEF = 4;
	localparam int COORD_W         = 32;
	localparam int COEFF_W         = 18;
	localparam int NUM_COEFF       = 5;
	localparam int MAX_DIST        = NUM_COEFF - 1;
	localparam int FRAC_BITS       = 16;
	localparam int CFG_IDX_W       = 3;

	// A pair of coordinates added, times one weight, summed over up to five terms.
	localparam int PAIR_W = COORD_W + 1;
	localparam int PROD_W = PAIR_W + COEFF_W;
	localparam int SUM_W  = PROD_W + 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEFF_CENTER = 3'd0,
		REG_COEFF_DIST1  = 3'd1,
		REG_COEFF_DIST2  = 3'd2,
		REG_COEFF_DIST3  = 3'd3,
		REG_COEFF_DIST4  = 3'd4
	} cfg_reg_e;

	typedef logic signed [COEFF_W-1:0] coeff_t;
	typedef coeff_t coeff_bank_t [NUM_COEFF];

	localparam coeff_bank_t COEFF_RESET = '{
		18'sd16739, 18'sd15320, 18'sd11065, 18'sd3972, -18'sd5958
	};

	// Control that travels beside the data of one result.
	typedef struct packed {
		logic valid;
		logic path_end;
	} stage_tag_t;

	// Load strobes of the two arithmetic stages.
	typedef struct packed {
		logic load_s2;
		logic load_s3;
	} pipe_ctl_t;

	function automatic int num_weights(input int half);
		return (half < MAX_DIST) ? half : MAX_DIST;
	endfunction

endpackage

// ===== rtl/core/sgps_window.sv =====
// Delay lines of both coordinates, path start and drain sequencing, and the
// first pipeline stage with the symmetric pair sums. Depends on sgps_pkg.
module sgps_window #(
	parameter int HALF_WINDOW = sgps_pkg::HALF_WINDOW_DEF,
	localparam int NW = sgps_pkg::num_weights(HALF_WINDOW)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic signed [sgps_pkg::COORD_W-1:0]    in_x,
	input  logic signed [sgps_pkg::COORD_W-1:0]    in_y,
	input  logic                                   in_last,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   s1_ready,
	output sgps_pkg::stage_tag_t                   tag_s1,
	output logic signed [sgps_pkg::PAIR_W-1:0]     pair_x_s1 [0:NW],
	output logic signed [sgps_pkg::PAIR_W-1:0]     pair_y_s1 [0:NW]
);
	import sgps_pkg::*;

	localparam int TAPS  = 2 * HALF_WINDOW + 1;
	localparam int CNT_W = $clog2(HALF_WINDOW + 1);
	localparam logic [CNT_W-1:0] HALF_CNT = CNT_W'(HALF_WINDOW);

	logic signed [COORD_W-1:0] win_x_q [TAPS];
	logic signed [COORD_W-1:0] win_y_q [TAPS];
	logic signed [COORD_W-1:0] nxt_x [TAPS];
	logic signed [COORD_W-1:0] nxt_y [TAPS];
	logic signed [COORD_W-1:0] src_x, src_y;
	logic [CNT_W-1:0] fill_q, step_q;
	logic [CNT_W:0]   drain_sum;
	logic drain_q, take, drain_step, step, load_all, emit, emit_end;

	assign in_ready   = !drain_q && s1_ready;
	assign take       = in_valid && in_ready;
	assign drain_step = drain_q && s1_ready;
	assign step       = take || drain_step;

	// While draining, the last point is shifted in again, which clamps on the right.
	assign src_x    = drain_q ? win_x_q[TAPS-1] : in_x;
	assign src_y    = drain_q ? win_y_q[TAPS-1] : in_y;
	assign load_all = !drain_q && (fill_q == '0);

	always_comb begin
		for (int m = 0; m < TAPS - 1; m++) begin
			nxt_x[m] = load_all ? src_x : win_x_q[m+1];
			nxt_y[m] = load_all ? src_y : win_y_q[m+1];
		end
		nxt_x[TAPS-1] = src_x;
		nxt_y[TAPS-1] = src_y;
	end

	assign drain_sum = {1'b0, step_q} + {1'b0, fill_q};
	assign emit      = drain_q ? (drain_sum >= {1'b0, HALF_CNT}) : (fill_q == HALF_CNT);
	assign emit_end  = drain_q && (step_q == HALF_CNT);

	always_ff @(posedge clk) begin
		if (step) begin
			for (int m = 0; m < TAPS; m++) begin
				win_x_q[m] <= nxt_x[m];
				win_y_q[m] <= nxt_y[m];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			step_q  <= '0;
			drain_q <= 1'b0;
		end else if (take) begin
			if (in_last) begin
				drain_q <= 1'b1;
				step_q  <= CNT_W'(1);
			end else if (fill_q != HALF_CNT) begin
				fill_q <= fill_q + 1'b1;
			end
		end else if (drain_step) begin
			if (step_q == HALF_CNT) begin
				drain_q <= 1'b0;
				fill_q  <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (s1_ready) begin
			tag_s1.valid    <= step && emit;
			tag_s1.path_end <= emit_end;
		end
	end

	// Equal weights at equal distance, so each pair is added before the multiply.
	always_ff @(posedge clk) begin
		if (s1_ready && step && emit) begin
			pair_x_s1[0] <= PAIR_W'(nxt_x[HALF_WINDOW]);
			pair_y_s1[0] <= PAIR_W'(nxt_y[HALF_WINDOW]);
			for (int d = 1; d <= NW; d++) begin
				pair_x_s1[d] <= PAIR_W'(nxt_x[HALF_WINDOW-d]) + PAIR_W'(nxt_x[HALF_WINDOW+d]);
				pair_y_s1[d] <= PAIR_W'(nxt_y[HALF_WINDOW-d]) + PAIR_W'(nxt_y[HALF_WINDOW+d]);
			end
		end
	end

endmodule

// ===== rtl/core/sgps_fir.sv =====
// Weighting, summing, shifting and saturation of one coordinate: pipeline
// stages two and three. Depends on sgps_pkg.
module sgps_fir #(
	parameter int HALF_WINDOW = sgps_pkg::HALF_WINDOW_DEF,
	localparam int NW = sgps_pkg::num_weights(HALF_WINDOW)
) (
	input  logic                                  clk,
	input  sgps_pkg::pipe_ctl_t                   ctl,
	input  sgps_pkg::coeff_bank_t                 weight,
	input  logic signed [sgps_pkg::PAIR_W-1:0]    pair_s1 [0:NW],
	output logic signed [sgps_pkg::COORD_W-1:0]   smooth_s3
);
	import sgps_pkg::*;

	localparam int SH_W = SUM_W - FRAC_BITS;

	logic signed [PROD_W-1:0]  prod_s2 [0:NW];
	logic signed [SUM_W-1:0]   acc;
	logic signed [SH_W-1:0]    shr;
	logic [SH_W-COORD_W:0]     high_bits;
	logic signed [COORD_W-1:0] sat;

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			for (int d = 0; d <= NW; d++) begin
				prod_s2[d] <= pair_s1[d] * weight[d];
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int d = 0; d <= NW; d++) begin
			acc = acc + SUM_W'(prod_s2[d]);
		end
	end

	// Dropping the fraction bits of a two's complement sum rounds towards minus infinity.
	assign shr       = $signed(acc[SUM_W-1:FRAC_BITS]);
	assign high_bits = shr[SH_W-1:COORD_W-1];

	always_comb begin
		if ((&high_bits) || !(|high_bits)) begin
			sat = shr[COORD_W-1:0];
		end else if (shr[SH_W-1]) begin
			sat = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(COORD_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			smooth_s3 <= sat;
		end
	end

endmodule

// ===== rtl/core/savitzky_golay_path_smoother.sv =====
// Top level of the Savitzky-Golay path smoother: coefficient registers,
// stage handshake and output. Depends on sgps_pkg, sgps_window and sgps_fir.
//
// Path points enter on the s_ group, one transfer per point, s_tlast on the
// final point of a path. Smoothed points leave on the m_ group, m_tlast on the
// final smoothed point. Coefficients must be written on the cfg_ port by the user,
// only between paths; the block does not enforce this. Output lags input by
// HALF_WINDOW points: the first HALF_WINDOW points of a path give no result, every
// later point gives one. The point that completes a result is registered in turn
// as pair sums, as products, and as the saturated sum that drives m_tvalid.
// One point is taken each cycle while s_tready is high. After a last point,
// s_tready stays low while the window drains, the last point shifted in again
// HALF_WINDOW times, giving the remaining results one per cycle unless stalled.
// Each stage holds its item while the next is full, and an empty stage takes
// a new item even while a result waits on m_tvalid, so s_tready drops only
// while draining, or once all three stages are occupied and m_tready is low.
// Reset clears the pipeline and the path state and loads the default weights.
module savitzky_golay_path_smoother #(
	parameter int HALF_WINDOW = sgps_pkg::HALF_WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [63:0]                       s_tdata,  // pos_x [31:0], pos_y [63:32]
	input  logic                              s_tlast,  // last_point
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [63:0]                       m_tdata,  // smooth_x [31:0], smooth_y [63:32]
	output logic                              m_tlast,  // path_end
	input  logic                              cfg_we,
	input  logic [sgps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sgps_pkg::COEFF_W-1:0]      cfg_wdata
);
	import sgps_pkg::*;

	localparam int NW = num_weights(HALF_WINDOW);

	coeff_bank_t coeff_q;
	stage_tag_t  tag_s1, tag_s2, tag_s3;
	pipe_ctl_t   ctl;
	logic s1_ready, s2_ready, s3_ready;
	logic signed [PAIR_W-1:0]  pair_x_s1 [0:NW];
	logic signed [PAIR_W-1:0]  pair_y_s1 [0:NW];
	logic signed [COORD_W-1:0] smooth_x_s3, smooth_y_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= COEFF_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEFF_CENTER: coeff_q[0] <= cfg_wdata;
				REG_COEFF_DIST1:  coeff_q[1] <= cfg_wdata;
				REG_COEFF_DIST2:  coeff_q[2] <= cfg_wdata;
				REG_COEFF_DIST3:  coeff_q[3] <= cfg_wdata;
				REG_COEFF_DIST4:  coeff_q[4] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign s3_ready    = !tag_s3.valid || m_tready;
	assign s2_ready    = !tag_s2.valid || s3_ready;
	assign s1_ready    = !tag_s1.valid || s2_ready;
	assign ctl.load_s2 = tag_s1.valid && s2_ready;
	assign ctl.load_s3 = tag_s2.valid && s3_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			if (s2_ready) begin
				tag_s2 <= tag_s1;
			end
			if (s3_ready) begin
				tag_s3 <= tag_s2;
			end
		end
	end

	sgps_window #(
		.HALF_WINDOW(HALF_WINDOW)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_x      ($signed(s_tdata[31:0])),
		.in_y      ($signed(s_tdata[63:32])),
		.in_last   (s_tlast),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.s1_ready  (s1_ready),
		.tag_s1    (tag_s1),
		.pair_x_s1 (pair_x_s1),
		.pair_y_s1 (pair_y_s1)
	);

	sgps_fir #(
		.HALF_WINDOW(HALF_WINDOW)
	) u_fir_x (
		.clk       (clk),
		.ctl       (ctl),
		.weight    (coeff_q),
		.pair_s1   (pair_x_s1),
		.smooth_s3 (smooth_x_s3)
	);

	sgps_fir #(
		.HALF_WINDOW(HALF_WINDOW)
	) u_fir_y (
		.clk       (clk),
		.ctl       (ctl),
		.weight    (coeff_q),
		.pair_s1   (pair_y_s1),
		.smooth_s3 (smooth_y_s3)
	);

	assign m_tvalid = tag_s3.valid;
	assign m_tlast  = tag_s3.path_end;
	assign m_tdata  = {smooth_y_s3, smooth_x_s3};

	// The window drains after a last point, so no new point may follow at once.
	a_drain_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("point accepted directly after a last point");

	// With every stage full and the output stalled, no point may enter.
	a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && tag_s2.valid && tag_s1.valid |-> !s_tready)
		else $error("point accepted into a full pipeline");

	// A held result must not be overwritten by the stage behind it.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s3.valid && !m_tready |-> !ctl.load_s3)
		else $error("stalled result overwritten");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for savitzky_golay_path_smoother: streams directed and random paths,
// predicts every smoothed point in SystemVerilog and checks each m_ transfer in order.
// Depends on sgps_pkg and the RTL of the path smoother only.
module testbench;
	import sgps_pkg::*;

	localparam int HW          = HALF_WINDOW_DEF;
	localparam int TAPS        = 2 * HW + 1;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;

	localparam logic signed [31:0] MAXC = 32'sh7FFFFFFF;
	localparam logic signed [31:0] MINC = 32'sh80000000;
	localparam coeff_t COEFF_MAX = 18'sh1FFFF;
	localparam coeff_t COEFF_MIN = 18'sh20000;

	typedef enum int {PATH_RANDOM, PATH_WALK, PATH_EXTREME} path_style_e;

	typedef struct packed {
		logic              pend;
		logic signed [31:0] sy;
		logic signed [31:0] sx;
	} smooth_pt_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               is_last;
		bit                 typed;
		smooth_pt_t         want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [63:0]          s_tdata;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [63:0]          m_tdata;
	logic                 m_tlast;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEFF_W-1:0]   cfg_wdata;

	// Mirror of the block: weights, delay lines and the path fill count.
	coeff_t             coeff_bank [NUM_COEFF];
	logic signed [31:0] win_x [TAPS];
	logic signed [31:0] win_y [TAPS];
	int                 fill_cnt;

	smooth_pt_t expected_pts [$];
	stim_row_t  directed_rows [$];
	smooth_pt_t no_pt;
	smooth_pt_t got_pt;
	smooth_pt_t want_pt;

	int fail_count;
	int cycle_cnt;
	bit tx_calm;
	bit rx_calm;
	bit want_hold;
	bit hold_done;
	int hold_left;

	savitzky_golay_path_smoother #(.HALF_WINDOW(HW)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [31:0] fir_out(input bit use_y);
		logic signed [63:0] acc;
		logic signed [63:0] tap;
		logic signed [63:0] wgt;
		int m;
		int d;
		acc = '0;
		for (m = 0; m < TAPS; m++) begin
			tap = use_y ? 64'(win_y[m]) : 64'(win_x[m]);
			d = m - HW;
			if (d < 0)
				d = -d;
			// Taps further out than the last weight register contribute nothing.
			if (d <= MAX_DIST)
				wgt = 64'(coeff_bank[d]);
			else
				wgt = '0;
			acc += tap * wgt;
		end
		acc = acc >>> FRAC_BITS;
		if (acc > 64'sd2147483647)
			return MAXC;
		else if (acc < -64'sd2147483648)
			return MINC;
		return acc[31:0];
	endfunction

	task automatic shift_window(input logic signed [31:0] x, input logic signed [31:0] y);
		int m;
		for (m = 0; m < TAPS - 1; m++) begin
			win_x[m] = win_x[m + 1];
			win_y[m] = win_y[m + 1];
		end
		win_x[TAPS - 1] = x;
		win_y[TAPS - 1] = y;
	endtask

	task automatic push_smoothed(input logic is_end);
		smooth_pt_t pt;
		pt.sx   = fir_out(1'b0);
		pt.sy   = fir_out(1'b1);
		pt.pend = is_end;
		expected_pts.insert(expected_pts.size(), pt);
	endtask

	// Advances the mirror by one accepted point and queues the points it completes.
	task automatic smooth_point(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic is_last);
		int prior;
		int j;
		int m;
		prior = fill_cnt;
		if (prior == 0) begin
			// The first point of a path fills the whole window, clamping on the left.
			for (m = 0; m < TAPS; m++) begin
				win_x[m] = x;
				win_y[m] = y;
			end
		end else begin
			shift_window(x, y);
		end
		if (!is_last) begin
			if (prior >= HW)
				push_smoothed(1'b0);
			fill_cnt = (prior < HW) ? prior + 1 : HW;
		end else begin
			// Draining repeats the last point, clamping on the right.
			for (j = 0; j <= HW; j++) begin
				if (j > 0)
					shift_window(x, y);
				if (j + prior >= HW)
					push_smoothed(j == HW);
			end
			fill_cnt = 0;
		end
	endtask

	task automatic write_coeff(input cfg_reg_e idx, input coeff_t value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		coeff_bank[idx] = value;
		@(negedge clk);
	endtask

	task automatic load_bank(input coeff_t c0, input coeff_t c1, input coeff_t c2,
			input coeff_t c3, input coeff_t c4);
		write_coeff(REG_COEFF_CENTER, c0);
		write_coeff(REG_COEFF_DIST1, c1);
		write_coeff(REG_COEFF_DIST2, c2);
		write_coeff(REG_COEFF_DIST3, c3);
		write_coeff(REG_COEFF_DIST4, c4);
		cfg_we <= 1'b0;
	endtask

	task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic is_last, input bit typed, input smooth_pt_t want);
		while (!tx_calm && $urandom_range(99) < 18) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {y, x};
		s_tlast  <= is_last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		smooth_point(x, y, is_last);
		// A single-point path has one result; its hand-worked value replaces the computed one.
		if (typed) begin
			void'(expected_pts.pop_back());
			expected_pts.insert(expected_pts.size(), want);
		end
		@(negedge clk);
	endtask

	task automatic add_row(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic is_last, input bit typed, input logic signed [31:0] wx,
			input logic signed [31:0] wy, input logic we);
		stim_row_t row;
		row.x         = x;
		row.y         = y;
		row.is_last   = is_last;
		row.typed     = typed;
		row.want.sx   = wx;
		row.want.sy   = wy;
		row.want.pend = we;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	function automatic logic signed [31:0] pick_coord(input path_style_e style,
			input logic signed [31:0] prev);
		int step;
		case (style)
			PATH_WALK: begin
				step = $urandom_range(524288);
				return prev + step - 262144;
			end
			PATH_EXTREME: begin
				case ($urandom_range(3))
					0: return MAXC;
					1: return MINC;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic send_path(input int len, input path_style_e style);
		logic signed [31:0] px;
		logic signed [31:0] py;
		int i;
		px = $urandom;
		py = $urandom;
		for (i = 0; i < len; i++) begin
			px = pick_coord(style, px);
			py = pick_coord(style, py);
			send_point(px, py, i == len - 1, 1'b0, no_pt);
		end
	endtask

	task automatic run_phase(input int n_items);
		int count;
		int len;
		int roll;
		path_style_e style;
		count = 0;
		while (count < n_items) begin
			// Mostly short paths, now and then a long one.
			if ($urandom_range(7) == 0)
				len = $urandom_range(30, 13);
			else
				len = $urandom_range(12, 1);
			roll = $urandom_range(99);
			if (roll < 50)
				style = PATH_WALK;
			else if (roll < 85)
				style = PATH_RANDOM;
			else
				style = PATH_EXTREME;
			send_path(len, style);
			count += len;
		end
	endtask

	// Weights change only once every result is out and the pipeline has emptied.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_pts.size() != 0)
			@(negedge clk);
		repeat (HW + 4) @(negedge clk);
	endtask

	// Receiver: random stalls, one long hold-off, calm stretches.
	initial begin
		m_tready = 1'b0;
		hold_done = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (want_hold && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (rx_calm) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 18);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_pt.sx   = m_tdata[31:0];
			got_pt.sy   = m_tdata[63:32];
			got_pt.pend = m_tlast;
			if (expected_pts.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected transfer: x=%0d y=%0d end=%0b",
						got_pt.sx, got_pt.sy, got_pt.pend);
			end else begin
				want_pt = expected_pts.pop_front();
				if (got_pt.sx !== want_pt.sx || got_pt.sy !== want_pt.sy ||
						got_pt.pend !== want_pt.pend) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: expected x=%0d y=%0d end=%0b, got x=%0d y=%0d end=%0b",
							want_pt.sx, want_pt.sy, want_pt.pend,
							got_pt.sx, got_pt.sy, got_pt.pend);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int r;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_COEFF_CENTER;
		cfg_wdata = '0;
		no_pt     = '0;
		fail_count = 0;
		cycle_cnt  = 0;
		tx_calm    = 1'b0;
		rx_calm    = 1'b0;
		want_hold  = 1'b0;
		fill_cnt   = 0;
		for (r = 0; r < NUM_COEFF; r++)
			coeff_bank[r] = COEFF_RESET[r];
		for (r = 0; r < TAPS; r++) begin
			win_x[r] = '0;
			win_y[r] = '0;
		end
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The reset weights sum to just over one, so a lone extreme point saturates.
		add_row(32'sd0, 32'sd0, 1'b1, 1'b1, 32'sd0, 32'sd0, 1'b1);
		add_row(MAXC, MINC, 1'b1, 1'b1, MAXC, MINC, 1'b1);
		add_row(MINC, MAXC, 1'b1, 1'b1, MINC, MAXC, 1'b1);
		// Short path of two points.
		add_row(32'sh00640000, 32'shFFFB0000, 1'b0, 1'b0, 0, 0, 1'b0);
		add_row(MAXC, MINC, 1'b1, 1'b0, 0, 0, 1'b0);
		// Path exactly one half-window long.
		for (r = 1; r <= HW; r++)
			add_row(r * 32'sh00010000, -r * 32'sh00030000, r == HW, 1'b0, 0, 0, 1'b0);
		// One point beyond the half-window, alternating extremes.
		for (r = 0; r <= HW; r++)
			add_row((r % 2) ? MINC : MAXC, (r % 2) ? MAXC : MINC, r == HW, 1'b0, 0, 0, 1'b0);
		// Longer ramp with odd values in the middle.
		for (r = 0; r < 10; r++)
			add_row((r == 5) ? MINC : r * 32'sh00100000 - 32'sh00400000,
				(r == 6) ? -32'sd1 : 32'sh12345678 - r * 32'sh00020000,
				r == 9, 1'b0, 0, 0, 1'b0);
		foreach (directed_rows[i])
			send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].is_last,
				directed_rows[i].typed, directed_rows[i].want);
		settle();

		// Long path against a stalled receiver so the pipeline fills and backs up.
		tx_calm   = 1'b1;
		want_hold = 1'b1;
		send_path(40, PATH_WALK);
		tx_calm   = 1'b0;
		run_phase(40);
		settle();

		load_bank(COEFF_W'($urandom), COEFF_W'($urandom), COEFF_W'($urandom),
			COEFF_W'($urandom), COEFF_W'($urandom));
		run_phase(50);
		settle();

		load_bank(COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX);
		run_phase(45);
		settle();

		load_bank(COEFF_MIN, COEFF_MIN, COEFF_MIN, COEFF_MIN, COEFF_MIN);
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		run_phase(50);
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		settle();

		load_bank(18'sd0, COEFF_MAX, COEFF_MIN, 18'sd0, COEFF_MAX);
		run_phase(45);
		settle();

		load_bank(COEFF_RESET[0], COEFF_RESET[1], COEFF_RESET[2], COEFF_RESET[3],
			COEFF_RESET[4]);
		run_phase(35);
		settle();

		repeat (HW + 8) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== savitzky_golay_path_smoother.f =====
rtl/core/sgps_pkg.sv
rtl/core/sgps_window.sv
rtl/core/sgps_fir.sv
rtl/core/savitzky_golay_path_smoother.sv
tb/testbench.sv
